@@ rtl/qte_pkg.sv @@
package qte_pkg;

  // Component, angle and iteration widths.
  localparam int CompW        = 16;
  localparam int AngleW       = 16;
  localparam int CordicStages = 16;

  // Components wider than 16 bits are cut down to 16 bits first.
  localparam int KeepShift = (CompW > 16) ? CompW - 16 : 0;
  localparam int RedW      = CompW - KeepShift;
  localparam int ProdW     = 2 * RedW;
  localparam int DotW      = ProdW + 1;
  localparam int NumW      = DotW;

  // Ratio terms are Q.28; the quotient never reaches 2^30.
  localparam int FracBits = 28;
  localparam int QuotW    = FracBits + 2;
  localparam int NumDivW  = DotW + FracBits + 1;
  localparam int TermW    = 32;

  // Square root of a Q.56 sum gives a Q.28 magnitude.
  localparam int RootW = FracBits + 1;
  localparam int SqW   = 2 * RootW;

  // CORDIC datapath and angle accumulator (2^32 units per turn).
  localparam int CordW = TermW + 2;
  localparam int ZW    = 32;

  // The threshold 1e-5 on the Q.28 grid.
  localparam int LockLimit = 2684;

  // Divider lanes.
  localparam int NumLanes = 7;
  localparam int LaneT1   = 0;
  localparam int LaneT2   = 1;
  localparam int LaneT5   = 2;
  localparam int LaneYN   = 3;
  localparam int LaneXN   = 4;
  localparam int LaneYL   = 5;
  localparam int LaneXL   = 6;

  // Queue between front and back.
  localparam int FifoPtrW    = 3;
  localparam int FifoDepth   = 1 << FifoPtrW;
  localparam int CntW        = FifoPtrW + 1;
  localparam int FrontStages = 3;

  // Pipeline latencies.
  localparam int DivLat   = QuotW + 2;
  localparam int CorLat   = CordicStages + 2;
  localparam int BackLat  = DivLat + 3 + RootW + 1 + CorLat + 1;
  localparam int TotalLat = FrontStages + 1 + BackLat;

  // Delay line that lines the terms up with the square root.
  localparam int DlDepth = RootW + 3;

  typedef logic signed [RedW-1:0]    comp_t;
  typedef logic signed [ProdW-1:0]   prod_t;
  typedef logic [DotW-1:0]           dot_t;
  typedef logic signed [NumW-1:0]    num_t;
  typedef logic [NumDivW-1:0]        numer_t;
  typedef logic [QuotW-1:0]          quo_t;
  typedef logic signed [TermW-1:0]   term_t;
  typedef logic [SqW-1:0]            sq_t;
  typedef logic [RootW-1:0]          root_t;
  typedef logic signed [CordW-1:0]   cord_t;
  typedef logic [ZW-1:0]             ang_t;
  typedef logic [AngleW-1:0]         angle_t;
  typedef logic [FifoPtrW-1:0]       ptr_t;
  typedef logic [CntW-1:0]           cnt_t;

  localparam term_t OneQ        = term_t'(64'd1 << FracBits);
  localparam ang_t  HalfTurn    = 32'h8000_0000;
  localparam ang_t  QuarterTurn = 32'h4000_0000;
  localparam ang_t  RoundAdd    = (32'd1 << (ZW - AngleW)) >> 1;

  // Rounded atan(2^-i) at 2^32 units per turn.
  localparam ang_t AtanTable [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // One beat between front and back: the dot product and the numerators.
  typedef struct packed {
    dot_t                        dot;
    logic [NumLanes-1:0][NumW-1:0] num;
  } qte_item_t;

  // Terms carried alongside the square root.
  typedef struct packed {
    term_t t1;
    term_t t2;
    term_t t5;
    term_t yn;
    term_t xn;
    term_t yl;
    term_t xl;
  } qte_terms_t;

endpackage

@@ rtl/quaternion_to_euler_angles_top.sv @@
// Quaternion to Euler angle converter.
// Input channel: drive quat_w_i, quat_x_i, quat_y_i and quat_z_i (signed
// Q1.14) with start_i high; the beat is taken at a rising edge where busy_o
// is low. Output channel: valid_o is high for exactly one cycle with
// angle_x_o, angle_y_o, angle_z_o (signed binary angles, value*pi/32768)
// and gimbal_locked_o; the receiver must take the beat in that cycle.
// The back is made up mostly of the 30-stage divider, the 29-stage square
// root and the CORDIC. One beat is accepted every cycle while busy_o is
// low. Beats leave in the order they came in.
// A three-stage front forms the products and sums and writes a small queue;
// the back reads the queue and runs the dividers, square root and CORDIC.
// busy_o rises only if the queue nears full, which a full-rate back never
// lets happen. Reset clears all valid flags and the queue; results in
// flight are dropped.
module quaternion_to_euler_angles_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [qte_pkg::CompW-1:0]    quat_w_i,
  input  logic [qte_pkg::CompW-1:0]    quat_x_i,
  input  logic [qte_pkg::CompW-1:0]    quat_y_i,
  input  logic [qte_pkg::CompW-1:0]    quat_z_i,
  output logic                         valid_o,
  output logic [qte_pkg::AngleW-1:0]   angle_x_o,
  output logic [qte_pkg::AngleW-1:0]   angle_y_o,
  output logic [qte_pkg::AngleW-1:0]   angle_z_o,
  output logic                         gimbal_locked_o
);

  logic               accept;
  logic               push, q_valid;
  qte_pkg::qte_item_t push_item, q_item;

  assign accept = start_i && !busy_o;

  qte_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .quat_w_i (quat_w_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .push_o   (push),
    .item_o   (push_item)
  );

  // The back takes a beat whenever the queue holds one.
  qte_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (q_valid),
    .valid_o (q_valid),
    .item_o  (q_item),
    .busy_o  (busy_o)
  );

  qte_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (q_valid),
    .item_i          (q_item),
    .valid_o         (valid_o),
    .angle_x_o       (angle_x_o),
    .angle_y_o       (angle_y_o),
    .angle_z_o       (angle_z_o),
    .gimbal_locked_o (gimbal_locked_o)
  );

  a_lock_zero_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && gimbal_locked_o |-> angle_z_o == '0)
    else $error("angle_z nonzero in gimbal lock");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, qte_pkg::TotalLat))
    else $error("result without an accepted beat");

endmodule

@@ rtl/qte_front.sv @@
module qte_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [qte_pkg::CompW-1:0]   quat_w_i,
  input  logic [qte_pkg::CompW-1:0]   quat_x_i,
  input  logic [qte_pkg::CompW-1:0]   quat_y_i,
  input  logic [qte_pkg::CompW-1:0]   quat_z_i,
  output logic                        push_o,
  output qte_pkg::qte_item_t          item_o
);

  logic [qte_pkg::FrontStages-1:0] vld_q;
  qte_pkg::comp_t w_q, x_q, y_q, z_q;
  qte_pkg::prod_t ww_q, xx_q, yy_q, zz_q, yx_q, zw_q, zy_q, xw_q, zx_q, yw_q;
  qte_pkg::qte_item_t item_q;

  // Track which stages hold a beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[qte_pkg::FrontStages-2:0], accept_i};
    end
  end

  // Stage 0 takes the components, stage 1 forms the products,
  // stage 2 sums them into the dot product and the numerators.
  always_ff @(posedge clk_i) begin
    w_q <= qte_pkg::comp_t'($signed(quat_w_i) >>> qte_pkg::KeepShift);
    x_q <= qte_pkg::comp_t'($signed(quat_x_i) >>> qte_pkg::KeepShift);
    y_q <= qte_pkg::comp_t'($signed(quat_y_i) >>> qte_pkg::KeepShift);
    z_q <= qte_pkg::comp_t'($signed(quat_z_i) >>> qte_pkg::KeepShift);

    ww_q <= w_q * w_q;
    xx_q <= x_q * x_q;
    yy_q <= y_q * y_q;
    zz_q <= z_q * z_q;
    yx_q <= y_q * x_q;
    zw_q <= z_q * w_q;
    zy_q <= z_q * y_q;
    xw_q <= x_q * w_q;
    zx_q <= z_q * x_q;
    yw_q <= y_q * w_q;

    item_q.dot <= qte_pkg::dot_t'(ww_q) + qte_pkg::dot_t'(xx_q) +
                  qte_pkg::dot_t'(yy_q) + qte_pkg::dot_t'(zz_q);
    item_q.num[qte_pkg::LaneT1] <= qte_pkg::num_t'(xx_q) + qte_pkg::num_t'(zz_q);
    item_q.num[qte_pkg::LaneT2] <= qte_pkg::num_t'(yx_q) - qte_pkg::num_t'(zw_q);
    item_q.num[qte_pkg::LaneT5] <= qte_pkg::num_t'(zy_q) + qte_pkg::num_t'(xw_q);
    item_q.num[qte_pkg::LaneYN] <= qte_pkg::num_t'(zx_q) - qte_pkg::num_t'(yw_q);
    item_q.num[qte_pkg::LaneXN] <= qte_pkg::num_t'(xx_q) + qte_pkg::num_t'(yy_q);
    item_q.num[qte_pkg::LaneYL] <= qte_pkg::num_t'(zx_q) + qte_pkg::num_t'(yw_q);
    item_q.num[qte_pkg::LaneXL] <= qte_pkg::num_t'(yy_q) + qte_pkg::num_t'(zz_q);
  end

  assign push_o = vld_q[qte_pkg::FrontStages-1];
  assign item_o = item_q;

endmodule

@@ rtl/qte_fifo.sv @@
module qte_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  qte_pkg::qte_item_t item_i,
  input  logic               pop_i,
  output logic               valid_o,
  output qte_pkg::qte_item_t item_o,
  output logic               busy_o
);

  qte_pkg::qte_item_t mem_q [qte_pkg::FifoDepth];
  qte_pkg::ptr_t      wr_q, rd_q;
  qte_pkg::cnt_t      cnt_q;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + qte_pkg::cnt_t'(push_i) - qte_pkg::cnt_t'(pop_i);
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  // Leave room for every beat still inside the front.
  assign busy_o  = (cnt_q >= qte_pkg::cnt_t'(qte_pkg::FifoDepth - qte_pkg::FrontStages));

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q < qte_pkg::cnt_t'(qte_pkg::FifoDepth))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue read while empty");

endmodule

@@ rtl/qte_div.sv @@
module qte_div (
  input  logic           clk_i,
  input  qte_pkg::num_t  num_i,
  input  qte_pkg::dot_t  dot_i,
  output qte_pkg::term_t ratio_o
);

  logic [qte_pkg::NumW-1:0] mag;
  qte_pkg::numer_t          numer;

  qte_pkg::dot_t rem_q [qte_pkg::QuotW];
  qte_pkg::quo_t low_q [qte_pkg::QuotW];
  qte_pkg::dot_t dot_q [qte_pkg::QuotW];
  qte_pkg::quo_t quo_q [qte_pkg::QuotW+1];
  logic          neg_q [qte_pkg::QuotW+1];
  logic          zero_q[qte_pkg::QuotW+1];

  logic [qte_pkg::DotW:0] trial [qte_pkg::QuotW];
  logic                   ge    [qte_pkg::QuotW];
  qte_pkg::dot_t          rem_d [qte_pkg::QuotW];

  // Magnitude, doubled and scaled to Q.28, plus half the divisor for rounding.
  always_comb begin
    mag   = num_i[qte_pkg::NumW-1] ? (~num_i + 1'b1) : num_i;
    numer = (qte_pkg::numer_t'(mag) << (qte_pkg::FracBits + 1)) +
            qte_pkg::numer_t'(dot_i >> 1);
  end

  // One quotient bit per stage: shift in a numerator bit, compare, subtract.
  always_comb begin
    for (int s = 0; s < qte_pkg::QuotW; s++) begin
      trial[s] = {rem_q[s], low_q[s][qte_pkg::QuotW-1]};
      ge[s]    = (trial[s] >= {1'b0, dot_q[s]});
      rem_d[s] = ge[s] ? qte_pkg::dot_t'(trial[s] - {1'b0, dot_q[s]})
                       : qte_pkg::dot_t'(trial[s]);
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= qte_pkg::dot_t'(numer >> qte_pkg::QuotW);
    low_q[0]  <= qte_pkg::quo_t'(numer);
    dot_q[0]  <= dot_i;
    quo_q[0]  <= '0;
    neg_q[0]  <= num_i[qte_pkg::NumW-1];
    zero_q[0] <= (dot_i == '0);
    for (int s = 0; s < qte_pkg::QuotW; s++) begin
      if (s < qte_pkg::QuotW - 1) begin
        rem_q[s+1] <= rem_d[s];
        low_q[s+1] <= low_q[s] << 1;
        dot_q[s+1] <= dot_q[s];
      end
      quo_q[s+1]  <= {quo_q[s][qte_pkg::QuotW-2:0], ge[s]};
      neg_q[s+1]  <= neg_q[s];
      zero_q[s+1] <= zero_q[s];
    end
    // A zero divisor gives a zero ratio; otherwise restore the sign.
    if (zero_q[qte_pkg::QuotW]) begin
      ratio_o <= '0;
    end else if (neg_q[qte_pkg::QuotW]) begin
      ratio_o <= -qte_pkg::term_t'(quo_q[qte_pkg::QuotW]);
    end else begin
      ratio_o <= qte_pkg::term_t'(quo_q[qte_pkg::QuotW]);
    end
  end

endmodule

@@ rtl/qte_sqrt.sv @@
module qte_sqrt (
  input  logic           clk_i,
  input  qte_pkg::sq_t   sq_i,
  output qte_pkg::root_t root_o
);

  logic [qte_pkg::RootW+1:0] rem_q  [qte_pkg::RootW];
  qte_pkg::root_t            root_q [qte_pkg::RootW];
  qte_pkg::sq_t              bits_q [qte_pkg::RootW];

  logic [qte_pkg::RootW+1:0] rem_d  [qte_pkg::RootW];
  qte_pkg::root_t            root_d [qte_pkg::RootW];
  qte_pkg::sq_t              bits_d [qte_pkg::RootW];

  logic [qte_pkg::RootW+1:0] in_rem;
  qte_pkg::root_t            in_root;
  qte_pkg::sq_t              in_bits;
  logic [qte_pkg::RootW+3:0] wide, trial;

  // One root bit per stage from the next pair of radicand bits.
  always_comb begin
    in_rem  = '0;
    in_root = '0;
    in_bits = '0;
    wide    = '0;
    trial   = '0;
    for (int s = 0; s < qte_pkg::RootW; s++) begin
      in_rem  = (s == 0) ? '0   : rem_q[s-1];
      in_root = (s == 0) ? '0   : root_q[s-1];
      in_bits = (s == 0) ? sq_i : bits_q[s-1];
      wide    = {in_rem, in_bits[qte_pkg::SqW-1 -: 2]};
      trial   = {2'b00, in_root, 2'b01};
      if (wide >= trial) begin
        rem_d[s]  = (qte_pkg::RootW+2)'(wide - trial);
        root_d[s] = {in_root[qte_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_d[s]  = (qte_pkg::RootW+2)'(wide);
        root_d[s] = {in_root[qte_pkg::RootW-2:0], 1'b0};
      end
      bits_d[s] = in_bits << 2;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < qte_pkg::RootW; s++) begin
      rem_q[s]  <= rem_d[s];
      root_q[s] <= root_d[s];
      bits_q[s] <= bits_d[s];
    end
  end

  assign root_o = root_q[qte_pkg::RootW-1];

endmodule

@@ rtl/qte_cordic.sv @@
module qte_cordic (
  input  logic            clk_i,
  input  qte_pkg::term_t  y_i,
  input  qte_pkg::term_t  x_i,
  output qte_pkg::angle_t angle_o
);

  qte_pkg::cord_t x0, y0;
  qte_pkg::ang_t  z0, sval, zf, rnd;

  qte_pkg::cord_t x_q   [qte_pkg::CordicStages];
  qte_pkg::cord_t y_q   [qte_pkg::CordicStages];
  qte_pkg::ang_t  z_q   [qte_pkg::CordicStages+1];
  logic           spc_q [qte_pkg::CordicStages+1];
  qte_pkg::ang_t  sv_q  [qte_pkg::CordicStages+1];

  qte_pkg::cord_t x_d [qte_pkg::CordicStages];
  qte_pkg::cord_t y_d [qte_pkg::CordicStages];
  qte_pkg::ang_t  z_d [qte_pkg::CordicStages];

  // Bring a vector with negative x into the right half plane.
  always_comb begin
    x0 = qte_pkg::cord_t'(x_i);
    y0 = qte_pkg::cord_t'(y_i);
    z0 = '0;
    if (x_i < 0) begin
      if (y_i > 0) begin
        x0 = qte_pkg::cord_t'(y_i);
        y0 = -qte_pkg::cord_t'(x_i);
        z0 = qte_pkg::QuarterTurn;
      end else begin
        x0 = -qte_pkg::cord_t'(y_i);
        y0 = qte_pkg::cord_t'(x_i);
        z0 = -qte_pkg::QuarterTurn;
      end
    end
    sval = (x_i >= 0) ? '0 : qte_pkg::HalfTurn;
  end

  // Vectoring micro-rotations, one per stage.
  always_comb begin
    for (int s = 0; s < qte_pkg::CordicStages; s++) begin
      if (y_q[s] > 0) begin
        x_d[s] = x_q[s] + (y_q[s] >>> s);
        y_d[s] = y_q[s] - (x_q[s] >>> s);
        z_d[s] = z_q[s] + qte_pkg::AtanTable[5'(s)];
      end else begin
        x_d[s] = x_q[s] - (y_q[s] >>> s);
        y_d[s] = y_q[s] + (x_q[s] >>> s);
        z_d[s] = z_q[s] - qte_pkg::AtanTable[5'(s)];
      end
    end
  end

  // Negate, then round half up to the output width.
  always_comb begin
    zf  = spc_q[qte_pkg::CordicStages] ? sv_q[qte_pkg::CordicStages]
                                       : z_q[qte_pkg::CordicStages];
    rnd = (-zf) + qte_pkg::RoundAdd;
  end

  always_ff @(posedge clk_i) begin
    x_q[0]   <= x0;
    y_q[0]   <= y0;
    z_q[0]   <= z0;
    spc_q[0] <= (y_i == 0);
    sv_q[0]  <= sval;
    for (int s = 0; s < qte_pkg::CordicStages; s++) begin
      if (s < qte_pkg::CordicStages - 1) begin
        x_q[s+1] <= x_d[s];
        y_q[s+1] <= y_d[s];
      end
      z_q[s+1]   <= z_d[s];
      spc_q[s+1] <= spc_q[s];
      sv_q[s+1]  <= sv_q[s];
    end
    angle_o <= rnd[qte_pkg::ZW-1 -: qte_pkg::AngleW];
  end

endmodule

@@ rtl/qte_back.sv @@
module qte_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  qte_pkg::qte_item_t item_i,
  output logic               valid_o,
  output qte_pkg::angle_t    angle_x_o,
  output qte_pkg::angle_t    angle_y_o,
  output qte_pkg::angle_t    angle_z_o,
  output logic               gimbal_locked_o
);

  logic [qte_pkg::BackLat-1:0] vld_q;
  qte_pkg::term_t     ratio [qte_pkg::NumLanes];
  qte_pkg::qte_terms_t dl_q [qte_pkg::DlDepth];
  qte_pkg::qte_terms_t tap;
  qte_pkg::sq_t       t1sq_q, t2sq_q, sq_q;
  logic signed [2*qte_pkg::TermW-1:0] t1sq, t2sq;
  qte_pkg::root_t     mag;
  logic               lk_q;
  logic [qte_pkg::CorLat-1:0] lkd_q;
  qte_pkg::term_t     ya_q, xa_q, yb_q, xb_q, yc_q, xc_q;
  qte_pkg::angle_t    ax, ay, az;

  // Beat tracking through the fixed-latency pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[qte_pkg::BackLat-2:0], valid_i};
    end
  end

  // One divider per ratio term.
  for (genvar g = 0; g < qte_pkg::NumLanes; g++) begin : g_lane
    qte_div u_div (
      .clk_i   (clk_i),
      .num_i   ($signed(item_i.num[g])),
      .dot_i   (item_i.dot),
      .ratio_o (ratio[g])
    );
  end

  assign t1sq = dl_q[0].t1 * dl_q[0].t1;
  assign t2sq = dl_q[0].t2 * dl_q[0].t2;
  assign tap  = dl_q[qte_pkg::DlDepth-1];

  // Terms, squares, their sum, and the terms delayed to meet the root.
  always_ff @(posedge clk_i) begin
    dl_q[0].t1 <= qte_pkg::OneQ - ratio[qte_pkg::LaneT1];
    dl_q[0].t2 <= ratio[qte_pkg::LaneT2];
    dl_q[0].t5 <= ratio[qte_pkg::LaneT5];
    dl_q[0].yn <= ratio[qte_pkg::LaneYN];
    dl_q[0].xn <= qte_pkg::OneQ - ratio[qte_pkg::LaneXN];
    dl_q[0].yl <= -ratio[qte_pkg::LaneYL];
    dl_q[0].xl <= qte_pkg::OneQ - ratio[qte_pkg::LaneXL];
    for (int i = 1; i < qte_pkg::DlDepth; i++) begin
      dl_q[i] <= dl_q[i-1];
    end
    t1sq_q <= t1sq[qte_pkg::SqW-1:0];
    t2sq_q <= t2sq[qte_pkg::SqW-1:0];
    sq_q   <= t1sq_q + t2sq_q;
  end

  qte_sqrt u_sqrt (
    .clk_i  (clk_i),
    .sq_i   (sq_q),
    .root_o (mag)
  );

  // Branch choice and the three atan2 operand pairs.
  always_ff @(posedge clk_i) begin
    lk_q <= (mag <= qte_pkg::root_t'(qte_pkg::LockLimit));
    ya_q <= -tap.t5;
    xa_q <= qte_pkg::term_t'(mag);
    if (mag <= qte_pkg::root_t'(qte_pkg::LockLimit)) begin
      yb_q <= tap.yl;
      xb_q <= tap.xl;
    end else begin
      yb_q <= tap.yn;
      xb_q <= tap.xn;
    end
    yc_q  <= tap.t2;
    xc_q  <= tap.t1;
    lkd_q <= {lkd_q[qte_pkg::CorLat-2:0], lk_q};
  end

  qte_cordic u_cordic_x (.clk_i(clk_i), .y_i(ya_q), .x_i(xa_q), .angle_o(ax));
  qte_cordic u_cordic_y (.clk_i(clk_i), .y_i(yb_q), .x_i(xb_q), .angle_o(ay));
  qte_cordic u_cordic_z (.clk_i(clk_i), .y_i(yc_q), .x_i(xc_q), .angle_o(az));

  // Result register.
  always_ff @(posedge clk_i) begin
    angle_x_o       <= ax;
    angle_y_o       <= ay;
    angle_z_o       <= lkd_q[qte_pkg::CorLat-1] ? '0 : az;
    gimbal_locked_o <= lkd_q[qte_pkg::CorLat-1];
  end

  assign valid_o = vld_q[qte_pkg::BackLat-1];

endmodule
